FILE: rtl/pnt_pkg.sv
package pnt_pkg;

    // Timebase: ticks per second
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned SEC_PER_MIN      = 60;

    // Derived widths
    localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned DIV_W  = $clog2(SEC_PER_MIN * TICKS_PER_SECOND + 1);
    localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
    localparam int unsigned PROD_W = TPS_W + 5;

    // Playback counter widths and their saturation limits
    localparam int unsigned HALF_W = 18;
    localparam int unsigned CYC_W  = 19;
    localparam int unsigned REST_W = 26;
    localparam int unsigned EXT_W  = DIV_W + REST_W;

    localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};
    localparam logic [CYC_W-1:0]  CYC_MAX  = {CYC_W{1'b1}};
    localparam logic [REST_W-1:0] REST_MAX = {REST_W{1'b1}};

    localparam logic [7:0] TEMPO_RESET = 8'd50;

    // Request kinds carried on tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

endpackage

FILE: rtl/packed_note_tone_generator.sv
// Channel   Direction  Content
// s_axis    in         tuser[0] func, tdata[15:0] note_word
// m_axis    out        tdata[0] buzzer, tdata[1] busy_res, tdata[7:2] zero
// cfg       in         data[7:0] tempo
//
// A tick request is answered in the cycle after it is accepted.
// A load request runs the shared serial divider for DIV_W (26) steps plus one
// post step per division, two divisions for a rest and three for a tone,
// after which the result register is loaded.
// Input ready is held low while the divider runs or a result waits unread.
// Reset (synchronous, active low) clears playback and sets tempo to 50.
module packed_note_tone_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] note_word
    input  logic [0:0]  i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] buzzer, [1] busy_res, [7:2] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned DIV_W  = pnt_pkg::DIV_W;
    localparam int unsigned TPS_W  = pnt_pkg::TPS_W;
    localparam int unsigned CNT_W  = pnt_pkg::CNT_W;
    localparam int unsigned HALF_W = pnt_pkg::HALF_W;
    localparam int unsigned CYC_W  = pnt_pkg::CYC_W;
    localparam int unsigned REST_W = pnt_pkg::REST_W;
    localparam int unsigned EXT_W  = pnt_pkg::EXT_W;
    localparam int unsigned PROD_W = pnt_pkg::PROD_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;

    // Division being run
    localparam logic [1:0] PH_TEMPO  = 2'd0;
    localparam logic [1:0] PH_REST   = 2'd1;
    localparam logic [1:0] PH_PERIOD = 2'd2;
    localparam logic [1:0] PH_CYC    = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_W:0]    r_rem, n_rem;
    logic [DIV_W-1:0]  r_dvd, n_dvd;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [DIV_W-1:0]  r_beat, n_beat;
    logic [TPS_W-1:0]  r_period, n_period;
    logic [12:0]       r_freq, n_freq;
    logic [4:0]        r_code, n_code;
    logic [7:0]        r_tempo;

    logic              r_playing, n_playing;
    logic              r_is_rest, n_is_rest;
    logic              r_high, n_high;
    logic [HALF_W-1:0] r_half_len, n_half_len;
    logic [HALF_W-1:0] r_half_cnt, n_half_cnt;
    logic [CYC_W-1:0]  r_cyc_left, n_cyc_left;
    logic [REST_W-1:0] r_rest_left, n_rest_left;

    logic              r_m_valid, n_m_valid;
    logic              r_buzz, n_buzz;
    logic              r_busy, n_busy;

    logic              s_acc;
    logic [DIV_W:0]    rem_sh;
    logic              sub_ok;
    logic [EXT_W-1:0]  quot_ext;
    logic [DIV_W-1:0]  beat_calc;
    logic [PROD_W-1:0] prod;
    logic [HALF_W-1:0] half_sat;
    logic [CYC_W-1:0]  cyc_sat;
    logic [REST_W-1:0] rest_sat;
    logic [7:0]        tempo_eff;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {6'd0, r_busy, r_buzz};
    assign o_cfg_ready     = 1'b1;

    // Divider step: shift in next dividend bit, subtract when it fits
    assign rem_sh = {r_rem[DIV_W-1:0], r_dvd[DIV_W-1]};
    assign sub_ok = (rem_sh >= {1'b0, r_dvs});

    // Post-processing of the finished quotient held in r_dvd
    assign quot_ext  = EXT_W'(r_dvd);
    assign beat_calc = (r_dvd << 6) - (r_dvd << 2);
    assign prod      = PROD_W'(r_code) * PROD_W'(r_dvd[TPS_W-1:0]);
    assign rest_sat  = (quot_ext > EXT_W'(pnt_pkg::REST_MAX)) ? pnt_pkg::REST_MAX
                                                              : REST_W'(r_dvd);
    assign cyc_sat   = (r_period == '0) ? '0 :
                       (quot_ext > EXT_W'(pnt_pkg::CYC_MAX)) ? pnt_pkg::CYC_MAX
                                                             : CYC_W'(r_dvd);
    assign half_sat  = ((EXT_W'(r_period) >> 1) > EXT_W'(pnt_pkg::HALF_MAX))
                       ? pnt_pkg::HALF_MAX : HALF_W'(r_period >> 1);
    assign tempo_eff = (r_tempo == 8'd0) ? 8'd1 : r_tempo;

    // Next-state logic for sequencer, playback and output register
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_beat      = r_beat;
        n_period    = r_period;
        n_freq      = r_freq;
        n_code      = r_code;
        n_playing   = r_playing;
        n_is_rest   = r_is_rest;
        n_high      = r_high;
        n_half_len  = r_half_len;
        n_half_cnt  = r_half_cnt;
        n_cyc_left  = r_cyc_left;
        n_rest_left = r_rest_left;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_buzz      = r_buzz;
        n_busy      = r_busy;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser[0] == pnt_pkg::FUNC_LOAD) begin
                        // Latch the note and start the beat length: ticks / tempo, later times 60
                        n_freq  = {i_s_axis_tdata[15:4], 1'b0};
                        n_code  = {1'b0, i_s_axis_tdata[3:0]} + 5'd1;
                        n_dvd   = DIV_W'(pnt_pkg::TICKS_PER_SECOND);
                        n_dvs   = DIV_W'(tempo_eff);
                        n_rem   = '0;
                        n_cnt   = CNT_W'(DIV_W);
                        n_phase = PH_TEMPO;
                        n_state = ST_DIV;
                    end else begin
                        // Advance playback by one tick and emit its level
                        n_m_valid = 1'b1;
                        n_buzz    = 1'b0;
                        n_busy    = r_playing;
                        if (r_playing) begin
                            if (r_is_rest) begin
                                if (r_rest_left != '0) begin
                                    n_rest_left = r_rest_left - 1'b1;
                                end
                                if (r_rest_left <= REST_W'(1)) begin
                                    n_playing = 1'b0;
                                end
                            end else begin
                                n_buzz = r_high;
                                if (r_half_cnt > HALF_W'(1)) begin
                                    n_half_cnt = r_half_cnt - 1'b1;
                                end else if (r_high) begin
                                    n_high     = 1'b0;
                                    n_half_cnt = r_half_len;
                                end else begin
                                    n_half_cnt = '0;
                                    if (r_cyc_left != '0) begin
                                        n_cyc_left = r_cyc_left - 1'b1;
                                    end
                                    if (r_cyc_left <= CYC_W'(1)) begin
                                        n_playing = 1'b0;
                                    end else begin
                                        n_high     = 1'b1;
                                        n_half_cnt = r_half_len;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle
                n_rem = sub_ok ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                n_dvd = {r_dvd[DIV_W-2:0], sub_ok};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                n_rem = '0;
                n_cnt = CNT_W'(DIV_W);
                unique case (r_phase)
                    PH_TEMPO: begin
                        n_beat  = beat_calc;
                        n_state = ST_DIV;
                        if (r_freq == '0) begin
                            n_dvd   = beat_calc;
                            n_dvs   = DIV_W'(r_code);
                            n_phase = PH_REST;
                        end else begin
                            n_dvd   = DIV_W'(pnt_pkg::TICKS_PER_SECOND);
                            n_dvs   = DIV_W'(r_freq);
                            n_phase = PH_PERIOD;
                        end
                    end
                    PH_PERIOD: begin
                        n_period = r_dvd[TPS_W-1:0];
                        n_dvd    = r_beat;
                        n_dvs    = DIV_W'(prod);
                        n_phase  = PH_CYC;
                        n_state  = ST_DIV;
                    end
                    PH_REST: begin
                        n_is_rest   = 1'b1;
                        n_high      = 1'b0;
                        n_half_len  = '0;
                        n_half_cnt  = '0;
                        n_cyc_left  = '0;
                        n_rest_left = rest_sat;
                        n_playing   = (rest_sat != '0);
                        n_m_valid   = 1'b1;
                        n_buzz      = 1'b0;
                        n_busy      = (rest_sat != '0);
                        n_state     = ST_IDLE;
                    end
                    PH_CYC: begin
                        n_is_rest   = 1'b0;
                        n_rest_left = '0;
                        n_half_len  = half_sat;
                        n_m_valid   = 1'b1;
                        n_buzz      = 1'b0;
                        n_state     = ST_IDLE;
                        if (half_sat != '0 && cyc_sat != '0) begin
                            n_playing  = 1'b1;
                            n_high     = 1'b1;
                            n_half_cnt = half_sat;
                            n_cyc_left = cyc_sat;
                            n_busy     = 1'b1;
                        end else begin
                            n_playing  = 1'b0;
                            n_high     = 1'b0;
                            n_half_cnt = '0;
                            n_cyc_left = '0;
                            n_busy     = 1'b0;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_TEMPO;
            r_cnt       <= '0;
            r_tempo     <= pnt_pkg::TEMPO_RESET;
            r_playing   <= 1'b0;
            r_is_rest   <= 1'b0;
            r_high      <= 1'b0;
            r_half_len  <= '0;
            r_half_cnt  <= '0;
            r_cyc_left  <= '0;
            r_rest_left <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tempo <= i_cfg_data;
            end
            r_playing   <= n_playing;
            r_is_rest   <= n_is_rest;
            r_high      <= n_high;
            r_half_len  <= n_half_len;
            r_half_cnt  <= n_half_cnt;
            r_cyc_left  <= n_cyc_left;
            r_rest_left <= n_rest_left;
            r_m_valid   <= n_m_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_dvs    <= n_dvs;
        r_beat   <= n_beat;
        r_period <= n_period;
        r_freq   <= n_freq;
        r_code   <= n_code;
        r_buzz   <= n_buzz;
        r_busy   <= n_busy;
    end

endmodule

FILE: rtl/pnt_checker.sv
module pnt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Buzzer only sounds while busy
    a_buzz_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && !o_m_axis_tdata[1]))
        else $error("buzzer high while not busy");

    // A tick request is answered in the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_axis_tuser[0] == pnt_pkg::FUNC_TICK) |=> o_m_axis_tvalid)
        else $error("tick result missing");

    // A load request blocks input while the divider runs
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_axis_tuser[0] == pnt_pkg::FUNC_LOAD) |=> !o_s_axis_tready)
        else $error("ready during note load");

endmodule

bind packed_note_tone_generator pnt_checker u_pnt_checker (.*);

FILE: sim/tb_packed_note_tone_generator.sv
module tb_packed_note_tone_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned SETTLE_CYCLES = 100;  // longer than a tone load
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned HOLD_AFTER = 300;
    localparam int unsigned PHASE_ITEMS = 310;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // [15:0] note_word
    logic [0:0]  i_s_axis_tuser;   // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // [0] buzzer, [1] busy_res, [7:2] zero
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    typedef struct packed {
        logic busy;
        logic buzzer;
    } t_pin_levels;

    // Tone predictor plus the queue of pin levels still owed by the block
    class t_tone_scoreboard;
        logic [7:0]                 tempo;
        bit                         playing;
        bit                         is_rest;
        bit                         high_phase;
        logic [pnt_pkg::HALF_W-1:0] half_len;
        logic [pnt_pkg::HALF_W-1:0] half_cnt;
        logic [pnt_pkg::CYC_W-1:0]  cycles_left;
        logic [pnt_pkg::REST_W-1:0] rest_left;
        t_pin_levels                expected_levels[$];
        int                         errors;
        int                         results_seen;

        function new();
            tempo = pnt_pkg::TEMPO_RESET;
            playing = 0;
            is_rest = 0;
            high_phase = 0;
            half_len = '0;
            half_cnt = '0;
            cycles_left = '0;
            rest_left = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_tempo(logic [7:0] bpm);
            tempo = bpm;
        endfunction

        function longint unsigned clip(longint unsigned v, longint unsigned lim);
            return (v > lim) ? lim : v;
        endfunction

        // Decode a packed note and arm the counters; zero-length notes stay idle
        function void load_note(logic [15:0] word);
            longint unsigned freq, code, bpm, beat, period, cyc;
            freq = 64'(word[15:4]) << 1;
            code = 64'(word[3:0]) + 1;
            bpm = (tempo == 8'd0) ? 1 : 64'(tempo);
            beat = pnt_pkg::SEC_PER_MIN * (pnt_pkg::TICKS_PER_SECOND / bpm);
            playing = 0;
            high_phase = 0;
            half_cnt = '0;
            cycles_left = '0;
            rest_left = '0;
            half_len = '0;
            if (freq == 0) begin
                is_rest = 1;
                rest_left = pnt_pkg::REST_W'(clip(beat / code, pnt_pkg::REST_MAX));
                playing = (rest_left != 0);
            end else begin
                period = pnt_pkg::TICKS_PER_SECOND / freq;
                cyc = (period == 0) ? 0 : beat / (code * period);
                is_rest = 0;
                half_len = pnt_pkg::HALF_W'(clip(period / 2, pnt_pkg::HALF_MAX));
                cycles_left = pnt_pkg::CYC_W'(clip(cyc, pnt_pkg::CYC_MAX));
                if (half_len != 0 && cycles_left != 0) begin
                    playing = 1;
                    high_phase = 1;
                    half_cnt = half_len;
                end else begin
                    cycles_left = '0;
                end
            end
        endfunction

        // Advance the predictor by one accepted request and queue its pin levels
        function void note_request(logic func, logic [15:0] word);
            t_pin_levels lv;
            lv = '0;
            if (func == pnt_pkg::FUNC_LOAD) begin
                load_note(word);
                lv.busy = playing;
            end else if (playing) begin
                lv.busy = 1'b1;
                if (is_rest) begin
                    if (rest_left != 0) rest_left--;
                    if (rest_left == 0) playing = 0;
                end else begin
                    lv.buzzer = high_phase;
                    if (half_cnt != 0) half_cnt--;
                    if (half_cnt == 0) begin
                        if (high_phase) begin
                            high_phase = 0;
                            half_cnt = half_len;
                        end else begin
                            if (cycles_left != 0) cycles_left--;
                            if (cycles_left == 0) begin
                                playing = 0;
                            end else begin
                                high_phase = 1;
                                half_cnt = half_len;
                            end
                        end
                    end
                end
            end
            expected_levels.push_back(lv);
        endfunction

        function void check_levels(logic [7:0] tdata);
            t_pin_levels lv;
            results_seen++;
            if (expected_levels.size() == 0) begin
                $error("result with nothing pending: tdata=%h", tdata);
                errors++;
                return;
            end
            lv = expected_levels.pop_front();
            if (tdata[0] !== lv.buzzer) begin
                $error("buzzer: expected %0b, actual %0b", lv.buzzer, tdata[0]);
                errors++;
            end
            if (tdata[1] !== lv.busy) begin
                $error("busy_res: expected %0b, actual %0b", lv.busy, tdata[1]);
                errors++;
            end
            if (tdata[7:2] !== 6'd0) begin
                $error("pad: expected %h, actual %h", 6'd0, tdata[7:2]);
                errors++;
            end
        endfunction
    endclass

    t_tone_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          n_sent = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          epoch_left = 0;
    int          stall_pct = 0;

    packed_note_tone_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: check each result, stall in epochs, hold off once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_levels(o_m_axis_tdata);
            if (epoch_left == 0) begin
                epoch_left = $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            epoch_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
                hold_done = 1;
                hold_left = LONG_HOLD;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Insert a random gap when the current burst runs out
    task automatic pace();
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= 16'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Offer one request and hold it until accepted
    task automatic send_item(input logic func, input logic [15:0] word);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= func;
        i_s_axis_tdata <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(func, word);
        n_sent++;
    endtask

    task automatic send_load(input logic [15:0] word);
        pace();
        send_item(pnt_pkg::FUNC_LOAD, word);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            pace();
            send_item(pnt_pkg::FUNC_TICK, 16'($urandom));
        end
    endtask

    // Wait until every result is back and the block has settled
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tempo(input logic [7:0] bpm);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= bpm;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_tempo(bpm);
    endtask

    // Bias toward high tones that toggle quickly, rests and low tones
    function automatic logic [15:0] pick_note_word();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return {1'b1, 11'($urandom), 4'($urandom)};
            2: return {12'h000, 4'($urandom)};
            default: return {8'h00, 4'($urandom_range(1, 15)), 4'($urandom)};
        endcase
    endfunction

    initial begin
        int target;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= pnt_pkg::FUNC_TICK;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick, rest, abort, zero-length tone, extremes of the word
        send_ticks(1);
        send_load(16'h0000);
        send_ticks(2);
        send_load(16'hFFFF);
        send_ticks(3);
        send_load(16'h001F);
        send_ticks(2);
        send_load(16'hFFF0);
        send_ticks(2);
        send_load(16'h0010);
        send_ticks(1);
        write_tempo(8'd0);
        send_load(16'h8005);
        send_ticks(2);

        // Random phrases under several tempos
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_tempo(8'd1);
                1: write_tempo(8'd255);
                2: write_tempo(8'd128);
                default: write_tempo(8'($urandom_range(0, 255)));
            endcase
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target) begin
                case ($urandom_range(0, 9))
                    0: begin
                        pace();
                        send_item(1'($urandom_range(0, 1)), 16'($urandom));
                    end
                    1: begin
                        send_load(pick_note_word());
                        send_load(pick_note_word());
                        send_ticks($urandom_range(0, 20));
                    end
                    default: begin
                        send_load(pick_note_word());
                        case ($urandom_range(0, 4))
                            0: send_ticks($urandom_range(0, 3));
                            1, 2: send_ticks($urandom_range(4, 40));
                            3: send_ticks($urandom_range(41, 150));
                            default: send_ticks($urandom_range(151, 400));
                        endcase
                    end
                endcase
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
